### rtl/core/prf_pkg.sv
// shared types and constants for the primitive root finder
// no dependencies
package prf_pkg;

    localparam int FIELD_W = 31;
    localparam int OP_W    = 5;

    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
    localparam logic [OP_W-1:0] OP_SQ       = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV_RD   = 5'd3;
    localparam logic [OP_W-1:0] OP_REST_Q   = 5'd4;
    localparam logic [OP_W-1:0] OP_DIV_PD   = 5'd5;
    localparam logic [OP_W-1:0] OP_PHI_SUB  = 5'd6;
    localparam logic [OP_W-1:0] OP_D_INC    = 5'd7;
    localparam logic [OP_W-1:0] OP_DIV_PR   = 5'd8;
    localparam logic [OP_W-1:0] OP_PHI_SUBR = 5'd9;
    localparam logic [OP_W-1:0] OP_FAC_INIT = 5'd10;
    localparam logic [OP_W-1:0] OP_FAC_Q    = 5'd11;
    localparam logic [OP_W-1:0] OP_FAC_REST = 5'd12;
    localparam logic [OP_W-1:0] OP_G_INIT   = 5'd13;
    localparam logic [OP_W-1:0] OP_GCD_INIT = 5'd14;
    localparam logic [OP_W-1:0] OP_DIV_AB   = 5'd15;
    localparam logic [OP_W-1:0] OP_GCD_STEP = 5'd16;
    localparam logic [OP_W-1:0] OP_G_INC    = 5'd17;
    localparam logic [OP_W-1:0] OP_I_INIT   = 5'd18;
    localparam logic [OP_W-1:0] OP_I_INC    = 5'd19;
    localparam logic [OP_W-1:0] OP_DIV_PF   = 5'd20;
    localparam logic [OP_W-1:0] OP_POW_INIT = 5'd21;
    localparam logic [OP_W-1:0] OP_MUL_AS   = 5'd22;
    localparam logic [OP_W-1:0] OP_MUL_SS   = 5'd23;
    localparam logic [OP_W-1:0] OP_DIV_PM   = 5'd24;
    localparam logic [OP_W-1:0] OP_ACC_REM  = 5'd25;
    localparam logic [OP_W-1:0] OP_SQ_REM   = 5'd26;
    localparam logic [OP_W-1:0] OP_RES_ONE  = 5'd27;
    localparam logic [OP_W-1:0] OP_RES_NONE = 5'd28;
    localparam logic [OP_W-1:0] OP_RES_G    = 5'd29;

    typedef logic [OP_W-1:0] op_t;

    typedef struct packed {
        logic m_is2;
        logic m_lt2;
        logic sq_le_rest;
        logic rest_gt1;
        logic div_done;
        logic rem_zero;
        logic hit;
        logic exists;
        logic nf_full;
        logic b_zero;
        logic a_is1;
        logic i_lt_nf;
        logic expo_zero;
        logic expo_lsb;
        logic acc_is1;
        logic g_le_m;
    } status_t;

endpackage

### rtl/core/prf_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing
module prf_div #(
    parameter int W = 31
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [2*W-1:0] dividend,
    input  logic [W-1:0]   divisor,
    output logic           done,
    output logic [2*W-1:0] quot,
    output logic [W-1:0]   rem
);
    localparam int DW = 2 * W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg, q_next;
    logic [W-1:0]  r_reg, r_next, dv_reg, dv_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [W:0]    trial;
    logic          fits;

    assign trial = {r_reg, q_reg[DW-1]};
    assign fits  = trial >= {1'b0, dv_reg};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            dv_next   = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next   = fits ? W'(trial - {1'b0, dv_reg}) : trial[W-1:0];
            q_next   = {q_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dv_reg  <= dv_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

### rtl/core/prf_dp.sv
// datapath: working registers, factor list, multiplier and shared divider
// depends on prf_pkg and prf_div
module prf_dp #(
    parameter int W   = 31,
    parameter int MAX = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  prf_pkg::op_t     op,
    input  logic [W-1:0]     modulus,
    output prf_pkg::status_t status,
    output logic [W-1:0]     root,
    output logic             found
);
    localparam int NF_W = $clog2(MAX + 1);
    localparam int IX_W = $clog2(MAX);

    logic [W-1:0]    m_reg, m_next, phi_reg, phi_next, rest_reg, rest_next;
    logic [W-1:0]    d_reg, d_next, g_reg, g_next, a_reg, a_next, b_reg, b_next;
    logic [W-1:0]    acc_reg, acc_next, sq_reg, sq_next, expo_reg, expo_next;
    logic [W-1:0]    root_reg, root_next;
    logic [2*W-1:0]  prod_reg, prod_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [NF_W-1:0] nf_reg, nf_next, idx_reg, idx_next;
    logic            hit_reg, hit_next, found_reg, found_next;
    logic [W-1:0]    fac_reg [MAX];
    logic            fac_we;
    logic [W-1:0]    fac_wd;

    logic            div_start, div_done;
    logic [2*W-1:0]  div_a, div_q;
    logic [W-1:0]    div_b, div_r;
    logic [1:0]      cnt_inc;

    prf_div #(.W(W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_a),
        .divisor (div_b),
        .done    (div_done),
        .quot    (div_q),
        .rem     (div_r)
    );

    // counter of distinct odd primes saturates at two
    assign cnt_inc = (cnt_reg == 2'd2) ? 2'd2 : cnt_reg + 2'd1;

    always_comb begin
        m_next = m_reg; phi_next = phi_reg; rest_next = rest_reg; d_next = d_reg;
        g_next = g_reg; a_next = a_reg; b_next = b_reg; acc_next = acc_reg;
        sq_next = sq_reg; expo_next = expo_reg; prod_next = prod_reg;
        cnt_next = cnt_reg; nf_next = nf_reg; idx_next = idx_reg; hit_next = hit_reg;
        root_next = root_reg; found_next = found_reg;
        fac_we = 1'b0; fac_wd = d_reg;
        div_start = 1'b0; div_a = {W'(0), rest_reg}; div_b = d_reg;
        case (op)
            prf_pkg::OP_LOAD: begin
                m_next = modulus; rest_next = modulus; phi_next = modulus;
                d_next = W'(2); cnt_next = 2'd0; hit_next = 1'b0;
            end
            prf_pkg::OP_SQ: prod_next = d_reg * d_reg;
            prf_pkg::OP_DIV_RD: div_start = 1'b1;
            prf_pkg::OP_REST_Q: begin
                rest_next = div_q[W-1:0]; hit_next = 1'b1;
            end
            prf_pkg::OP_DIV_PD: begin
                div_start = 1'b1; div_a = {W'(0), phi_reg};
            end
            prf_pkg::OP_PHI_SUB: begin
                phi_next = phi_reg - div_q[W-1:0];
                if (d_reg != W'(2)) cnt_next = cnt_inc;
                d_next = d_reg + 1'b1; hit_next = 1'b0;
            end
            prf_pkg::OP_D_INC: begin
                d_next = d_reg + 1'b1; hit_next = 1'b0;
            end
            prf_pkg::OP_DIV_PR: begin
                div_start = 1'b1; div_a = {W'(0), phi_reg}; div_b = rest_reg;
            end
            prf_pkg::OP_PHI_SUBR: begin
                phi_next = phi_reg - div_q[W-1:0];
                if (rest_reg != W'(2)) cnt_next = cnt_inc;
            end
            prf_pkg::OP_FAC_INIT: begin
                rest_next = phi_reg; d_next = W'(2); nf_next = '0; hit_next = 1'b0;
            end
            prf_pkg::OP_FAC_Q: begin
                rest_next = div_q[W-1:0]; hit_next = 1'b1;
                if (!hit_reg) begin
                    fac_we = 1'b1; nf_next = nf_reg + 1'b1;
                end
            end
            prf_pkg::OP_FAC_REST: begin
                fac_we = 1'b1; fac_wd = rest_reg; nf_next = nf_reg + 1'b1;
            end
            prf_pkg::OP_G_INIT: g_next = W'(2);
            prf_pkg::OP_GCD_INIT: begin
                a_next = m_reg; b_next = g_reg;
            end
            prf_pkg::OP_DIV_AB: begin
                div_start = 1'b1; div_a = {W'(0), a_reg}; div_b = b_reg;
            end
            prf_pkg::OP_GCD_STEP: begin
                a_next = b_reg; b_next = div_r;
            end
            prf_pkg::OP_G_INC: g_next = g_reg + 1'b1;
            prf_pkg::OP_I_INIT: idx_next = '0;
            prf_pkg::OP_I_INC: idx_next = idx_reg + 1'b1;
            prf_pkg::OP_DIV_PF: begin
                div_start = 1'b1; div_a = {W'(0), phi_reg};
                div_b = fac_reg[idx_reg[IX_W-1:0]];
            end
            prf_pkg::OP_POW_INIT: begin
                expo_next = div_q[W-1:0]; acc_next = W'(1); sq_next = g_reg;
            end
            prf_pkg::OP_MUL_AS: prod_next = acc_reg * sq_reg;
            prf_pkg::OP_MUL_SS: prod_next = sq_reg * sq_reg;
            prf_pkg::OP_DIV_PM: begin
                div_start = 1'b1; div_a = prod_reg; div_b = m_reg;
            end
            prf_pkg::OP_ACC_REM: acc_next = div_r;
            prf_pkg::OP_SQ_REM: begin
                sq_next = div_r; expo_next = expo_reg >> 1;
            end
            prf_pkg::OP_RES_ONE: begin
                root_next = W'(1); found_next = 1'b1;
            end
            prf_pkg::OP_RES_NONE: begin
                root_next = '0; found_next = 1'b0;
            end
            prf_pkg::OP_RES_G: begin
                root_next = g_reg; found_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        m_reg <= m_next; phi_reg <= phi_next; rest_reg <= rest_next; d_reg <= d_next;
        g_reg <= g_next; a_reg <= a_next; b_reg <= b_next; acc_reg <= acc_next;
        sq_reg <= sq_next; expo_reg <= expo_next; prod_reg <= prod_next;
        cnt_reg <= cnt_next; nf_reg <= nf_next; idx_reg <= idx_next; hit_reg <= hit_next;
        root_reg <= root_next; found_reg <= found_next;
        if (fac_we) fac_reg[nf_reg[IX_W-1:0]] <= fac_wd;
    end

    always_comb begin
        status.m_is2      = m_reg == W'(2);
        status.m_lt2      = m_reg < W'(2);
        status.sq_le_rest = prod_reg <= {W'(0), rest_reg};
        status.rest_gt1   = rest_reg > W'(1);
        status.div_done   = div_done;
        status.rem_zero   = div_r == '0;
        status.hit        = hit_reg;
        status.exists     = (m_reg == W'(4)) || (cnt_reg == 2'd1 && m_reg[1:0] != 2'd0);
        status.nf_full    = nf_reg == NF_W'(MAX);
        status.b_zero     = b_reg == '0;
        status.a_is1      = a_reg == W'(1);
        status.i_lt_nf    = idx_reg < nf_reg;
        status.expo_zero  = expo_reg == '0;
        status.expo_lsb   = expo_reg[0];
        status.acc_is1    = acc_reg == W'(1);
        status.g_le_m     = g_reg <= m_reg;
    end

    assign root  = root_reg;
    assign found = found_reg;
endmodule

### rtl/core/prf_ctrl.sv
// sequencer that steps the datapath through totient, factoring and candidate tests
// depends on prf_pkg
module prf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  prf_pkg::status_t st,
    output prf_pkg::op_t     op
);
    localparam logic [4:0] S_IDLE = 5'd0,  S_CHK0 = 5'd1,  S_T_SQ = 5'd2,  S_T_CHK = 5'd3;
    localparam logic [4:0] S_T_W = 5'd4,   S_T_RD = 5'd5,  S_T_PW = 5'd6,  S_T_TAIL = 5'd7;
    localparam logic [4:0] S_T_TW = 5'd8,  S_EX = 5'd9,    S_F_SQ = 5'd10, S_F_CHK = 5'd11;
    localparam logic [4:0] S_F_W = 5'd12,  S_F_RD = 5'd13, S_F_TAIL = 5'd14, S_G_INIT = 5'd15;
    localparam logic [4:0] S_G_TOP = 5'd16, S_GCD = 5'd17, S_GCD_W = 5'd18, S_P_TOP = 5'd19;
    localparam logic [4:0] S_P_W = 5'd20,  S_POW = 5'd21,  S_M1 = 5'd22,   S_M1W = 5'd23;
    localparam logic [4:0] S_SQM = 5'd24,  S_M3 = 5'd25,   S_M3W = 5'd26,  S_OUT = 5'd27;

    logic [4:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op = prf_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: if (s_valid) begin
                op = prf_pkg::OP_LOAD; state_next = S_CHK0;
            end
            S_CHK0: begin
                if (st.m_is2) begin
                    op = prf_pkg::OP_RES_ONE; state_next = S_OUT;
                end else if (st.m_lt2) begin
                    op = prf_pkg::OP_RES_NONE; state_next = S_OUT;
                end else state_next = S_T_SQ;
            end
            S_T_SQ: begin
                op = prf_pkg::OP_SQ; state_next = S_T_CHK;
            end
            S_T_CHK: begin
                if (st.sq_le_rest) begin
                    op = prf_pkg::OP_DIV_RD; state_next = S_T_W;
                end else state_next = S_T_TAIL;
            end
            S_T_W: if (st.div_done) begin
                if (st.rem_zero) begin
                    op = prf_pkg::OP_REST_Q; state_next = S_T_RD;
                end else if (st.hit) begin
                    op = prf_pkg::OP_DIV_PD; state_next = S_T_PW;
                end else begin
                    op = prf_pkg::OP_D_INC; state_next = S_T_SQ;
                end
            end
            S_T_RD: begin
                op = prf_pkg::OP_DIV_RD; state_next = S_T_W;
            end
            S_T_PW: if (st.div_done) begin
                op = prf_pkg::OP_PHI_SUB; state_next = S_T_SQ;
            end
            S_T_TAIL: begin
                if (st.rest_gt1) begin
                    op = prf_pkg::OP_DIV_PR; state_next = S_T_TW;
                end else state_next = S_EX;
            end
            S_T_TW: if (st.div_done) begin
                op = prf_pkg::OP_PHI_SUBR; state_next = S_EX;
            end
            S_EX: begin
                if (!st.exists) begin
                    op = prf_pkg::OP_RES_NONE; state_next = S_OUT;
                end else begin
                    op = prf_pkg::OP_FAC_INIT; state_next = S_F_SQ;
                end
            end
            S_F_SQ: begin
                op = prf_pkg::OP_SQ; state_next = S_F_CHK;
            end
            S_F_CHK: begin
                if (st.sq_le_rest) begin
                    op = prf_pkg::OP_DIV_RD; state_next = S_F_W;
                end else state_next = S_F_TAIL;
            end
            S_F_W: if (st.div_done) begin
                if (st.rem_zero) begin
                    if (!st.hit && st.nf_full) begin
                        op = prf_pkg::OP_RES_NONE; state_next = S_OUT;
                    end else begin
                        op = prf_pkg::OP_FAC_Q; state_next = S_F_RD;
                    end
                end else begin
                    op = prf_pkg::OP_D_INC; state_next = S_F_SQ;
                end
            end
            S_F_RD: begin
                op = prf_pkg::OP_DIV_RD; state_next = S_F_W;
            end
            S_F_TAIL: begin
                if (st.rest_gt1 && st.nf_full) begin
                    op = prf_pkg::OP_RES_NONE; state_next = S_OUT;
                end else begin
                    if (st.rest_gt1) op = prf_pkg::OP_FAC_REST;
                    state_next = S_G_INIT;
                end
            end
            S_G_INIT: begin
                op = prf_pkg::OP_G_INIT; state_next = S_G_TOP;
            end
            S_G_TOP: begin
                if (!st.g_le_m) begin
                    op = prf_pkg::OP_RES_NONE; state_next = S_OUT;
                end else begin
                    op = prf_pkg::OP_GCD_INIT; state_next = S_GCD;
                end
            end
            S_GCD: begin
                if (st.b_zero) begin
                    if (st.a_is1) begin
                        op = prf_pkg::OP_I_INIT; state_next = S_P_TOP;
                    end else begin
                        op = prf_pkg::OP_G_INC; state_next = S_G_TOP;
                    end
                end else begin
                    op = prf_pkg::OP_DIV_AB; state_next = S_GCD_W;
                end
            end
            S_GCD_W: if (st.div_done) begin
                op = prf_pkg::OP_GCD_STEP; state_next = S_GCD;
            end
            S_P_TOP: begin
                if (!st.i_lt_nf) begin
                    op = prf_pkg::OP_RES_G; state_next = S_OUT;
                end else begin
                    op = prf_pkg::OP_DIV_PF; state_next = S_P_W;
                end
            end
            S_P_W: if (st.div_done) begin
                op = prf_pkg::OP_POW_INIT; state_next = S_POW;
            end
            S_POW: begin
                if (st.expo_zero) begin
                    if (st.acc_is1) begin
                        op = prf_pkg::OP_G_INC; state_next = S_G_TOP;
                    end else begin
                        op = prf_pkg::OP_I_INC; state_next = S_P_TOP;
                    end
                end else if (st.expo_lsb) begin
                    op = prf_pkg::OP_MUL_AS; state_next = S_M1;
                end else begin
                    op = prf_pkg::OP_MUL_SS; state_next = S_M3;
                end
            end
            S_M1: begin
                op = prf_pkg::OP_DIV_PM; state_next = S_M1W;
            end
            S_M1W: if (st.div_done) begin
                op = prf_pkg::OP_ACC_REM; state_next = S_SQM;
            end
            S_SQM: begin
                op = prf_pkg::OP_MUL_SS; state_next = S_M3;
            end
            S_M3: begin
                op = prf_pkg::OP_DIV_PM; state_next = S_M3W;
            end
            S_M3W: if (st.div_done) begin
                op = prf_pkg::OP_SQ_REM; state_next = S_POW;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT;
endmodule

### rtl/core/primitive_root_finder_top.sv
// top level of the primitive root finder
// depends on prf_pkg, prf_ctrl, prf_dp (and prf_div below it)
//
// usage
// - input channel s_valid / s_ready / s_modulus carries one request: the modulus m
// - result channel m_valid / m_ready / m_root / m_found returns one result per request
// - m_found is 1 with the smallest primitive root in m_root, else m_root is 0
// - only the low MOD_BITS bits of s_modulus are used
// - one request at a time: s_ready is high only while the block is idle
// - every division and every modular reduction runs on one shared restoring
//   divider that retires one quotient bit a cycle
// - trial division finds phi and the primes of phi, then each candidate g
//   gets a gcd with m and, per prime of phi, a modular power
// - the result waits in its output register while m_ready is low; no new
//   request is taken until it leaves
// - synchronous active-low reset returns the block to idle with no result
module primitive_root_finder_top #(
    parameter int MOD_BITS          = 31,
    parameter int MAX_PRIME_FACTORS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [30:0] s_modulus,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_root,
    output logic        m_found
);
    prf_pkg::op_t     op;
    prf_pkg::status_t st;
    logic [MOD_BITS-1:0] root;

    // sequencer
    prf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .op      (op)
    );

    // registers, multiplier and divider
    prf_dp #(.W(MOD_BITS), .MAX(MAX_PRIME_FACTORS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .modulus (s_modulus[MOD_BITS-1:0]),
        .status  (st),
        .root    (root),
        .found   (m_found)
    );

    assign m_root = prf_pkg::FIELD_W'(root);
endmodule

### test/primitive_root_finder_top_tb.sv
`timescale 1ns / 100ps
// testbench for primitive_root_finder_top: moduli in, smallest primitive root out
// depends on prf_pkg and the primitive root finder rtl; checks against its own root search
module primitive_root_finder_top_tb;

    localparam int WATCHDOG_CYCLES = 4000000;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [prf_pkg::FIELD_W-1:0]  s_modulus;
    logic                         m_valid;
    logic                         m_ready;
    logic [prf_pkg::FIELD_W-1:0]  m_root;
    logic                         m_found;

    typedef struct {
        logic [prf_pkg::FIELD_W-1:0] root;
        logic                        found;
    } root_result_t;

    // expected roots, oldest first
    root_result_t pending_roots[$];
    int           error_count;
    int           request_count;
    int           result_count;
    int           found_count;
    int           idle_cycles;
    bit           sink_stall_free;   // stretch where the result side never stalls

    primitive_root_finder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_modulus (s_modulus),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_root    (m_root),
        .m_found   (m_found)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // modular power by square-and-multiply
    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % m;
        sq  = b % m;
        while (e > 0) begin
            if (e[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc;
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // smallest primitive root of m, found = 0 when there is none
    function automatic root_result_t smallest_root(logic [prf_pkg::FIELD_W-1:0] modulus);
        root_result_t    res;
        longint unsigned m;
        longint unsigned rest;
        longint unsigned phi;
        longint unsigned d;
        longint unsigned g;
        longint unsigned primes[$];
        int              odd_primes;
        bit              ok;
        res.root  = '0;
        res.found = 1'b0;
        m = modulus;
        if (m == 2) begin
            res.root  = 1;
            res.found = 1'b1;
            return res;
        end
        if (m < 2) return res;
        // totient, counting distinct odd primes of m
        rest = m;
        phi  = m;
        odd_primes = 0;
        for (d = 2; d * d <= rest; d++) begin
            if (rest % d == 0) begin
                while (rest % d == 0) rest = rest / d;
                phi = phi - phi / d;
                if (d != 2) odd_primes++;
            end
        end
        if (rest > 1) begin
            phi = phi - phi / rest;
            if (rest != 2) odd_primes++;
        end
        // roots exist only for 4, p^a and 2*p^a
        if (!(m == 4 || (odd_primes == 1 && m % 4 != 0))) return res;
        rest = phi;
        for (d = 2; d * d <= rest; d++) begin
            if (rest % d == 0) begin
                primes.push_back(d);
                while (rest % d == 0) rest = rest / d;
            end
        end
        if (rest > 1) primes.push_back(rest);
        for (g = 2; g <= m; g++) begin
            if (gcd_of(g, m) != 1) continue;
            ok = 1'b1;
            foreach (primes[i]) if (ok) ok = pow_mod(g, phi / primes[i], m) != 1;
            if (ok) begin
                res.root  = g[prf_pkg::FIELD_W-1:0];
                res.found = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 2));
        return int'($urandom_range(5, 40));
    endfunction

    // result side stalls, with stall-free stretches mixed in
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) sink_stall_free = ~sink_stall_free;
            if (sink_stall_free)
                m_ready <= 1'b1;
            else if ($urandom_range(0, 19) == 0)
                m_ready <= 1'b0;  // start of a long stall
            else if (!m_ready && $urandom_range(0, 9) != 0 && $urandom_range(0, 3) == 0)
                m_ready <= 1'b0;
            else
                m_ready <= $urandom_range(0, 3) != 0;
        end
    end

    // compare every result against the oldest expected root
    always @(posedge aclk) begin
        root_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_roots.size() == 0) begin
                $error("result with no request pending: root %0d found %0b", m_root, m_found);
                error_count++;
            end else begin
                exp_res = pending_roots.pop_front();
                if (m_root !== exp_res.root) begin
                    $error("root mismatch: expected %0d, actual %0d", exp_res.root, m_root);
                    error_count++;
                end
                if (m_found !== exp_res.found) begin
                    $error("found mismatch: expected %0b, actual %0b", exp_res.found, m_found);
                    error_count++;
                end
                if (exp_res.found) found_count++;
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog expired, nothing accepted for %0d cycles", idle_cycles);
            $display("primitive_root_finder_top_tb NOT OK");
            $finish;
        end
    end

    // one modulus request: called at a falling edge, returns at a falling edge
    task automatic send_modulus(logic [prf_pkg::FIELD_W-1:0] modulus);
        int gap;
        s_valid   = 1'b1;
        s_modulus = modulus;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_roots.push_back(smallest_root(modulus));
        request_count++;
        @(negedge aclk);
        s_valid   = 1'b0;
        s_modulus = prf_pkg::FIELD_W'($urandom());  // payload is don't-care while idle
        gap = rand_gap();
        repeat (gap) @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_roots.size() != 0) @(negedge aclk);
    endtask

    // modulus two, zero, one, four, eight, primes, prime powers, 2*p^a, non-root cases
    task automatic test_special_moduli();
        logic [prf_pkg::FIELD_W-1:0] special[] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 15, 18,
                                                   25, 27, 49, 50, 54, 97, 121, 1024, 998,
                                                   2310};
        foreach (special[i]) send_modulus(special[i]);
    endtask

    // wide moduli whose factorization is quick: top bits, prime power, power of two
    task automatic test_large_moduli();
        send_modulus(31'h7FFF_FFFE);
        send_modulus(31'd1162261467);   // 3^19, root exists
        send_modulus(31'h4000_0000);
    endtask

    // sender holds off until every pending root has come back
    task automatic test_drain_pause();
        wait_drained();
        send_modulus(prf_pkg::FIELD_W'($urandom_range(3, 500)));
        wait_drained();
        send_modulus(prf_pkg::FIELD_W'($urandom_range(3, 500)));
    endtask

    // mostly small moduli, biased toward ones that have a root
    task automatic test_random_moduli(int count);
        int unsigned p;
        int unsigned m;
        int unsigned sel;
        repeat (count) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                // power of a small odd base, or twice one
                p = $urandom_range(1, 40) * 2 + 1;
                m = p;
                while ($urandom_range(0, 2) == 0 && m * p < 4000) m = m * p;
                if ($urandom_range(0, 1) == 1) m = m * 2;
            end else if (sel < 9) begin
                m = $urandom_range(0, 3000);
            end else begin
                m = $urandom_range(3000, 40000);
            end
            send_modulus(m[prf_pkg::FIELD_W-1:0]);
        end
    endtask

    initial begin
        error_count     = 0;
        request_count   = 0;
        result_count    = 0;
        found_count     = 0;
        idle_cycles     = 0;
        sink_stall_free = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_modulus = '0;
        m_ready   = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_special_moduli();
        test_large_moduli();
        test_drain_pause();
        test_random_moduli(38);
        test_drain_pause();
        test_random_moduli(38);

        wait_drained();
        repeat (200) @(negedge aclk);
        $display("covered %0d moduli, %0d results, %0d of them with a root",
                 request_count, result_count, found_count);
        if (error_count == 0 && pending_roots.size() == 0) begin
            $display("primitive_root_finder_top_tb OK");
        end else begin
            $display("primitive_root_finder_top_tb NOT OK");
        end
        $finish;
    end

endmodule
